FILE: sv/arm_data_processing_alu_unit_assert.svh
// Assertion macros shared by the ALU unit RTL.
`ifndef ARM_DATA_PROCESSING_ALU_UNIT_ASSERT_SVH
`define ARM_DATA_PROCESSING_ALU_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define ADP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ADP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ADP_ASSERT(lbl, prop, msg)
`define ADP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: sv/adp_pkg.sv
// Shared types and codes for the ARM data-processing ALU pipeline.
package adp_pkg;

    // ALU opcodes, instruction bits 24:21.
    localparam logic [3:0] OP_AND = 4'h0;
    localparam logic [3:0] OP_EOR = 4'h1;
    localparam logic [3:0] OP_SUB = 4'h2;
    localparam logic [3:0] OP_RSB = 4'h3;
    localparam logic [3:0] OP_ADD = 4'h4;
    localparam logic [3:0] OP_ADC = 4'h5;
    localparam logic [3:0] OP_SBC = 4'h6;
    localparam logic [3:0] OP_RSC = 4'h7;
    localparam logic [3:0] OP_TST = 4'h8;
    localparam logic [3:0] OP_TEQ = 4'h9;
    localparam logic [3:0] OP_CMP = 4'hA;
    localparam logic [3:0] OP_CMN = 4'hB;
    localparam logic [3:0] OP_ORR = 4'hC;
    localparam logic [3:0] OP_MOV = 4'hD;
    localparam logic [3:0] OP_BIC = 4'hE;
    localparam logic [3:0] OP_MVN = 4'hF;

    // Condition codes, instruction bits 31:28.
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_MI = 4'h4;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_VS = 4'h6;
    localparam logic [3:0] COND_VC = 4'h7;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;

    // Internal shifter operations.
    localparam logic [2:0] SH_LSL = 3'd0;
    localparam logic [2:0] SH_LSR = 3'd1;
    localparam logic [2:0] SH_ASR = 3'd2;
    localparam logic [2:0] SH_ROR = 3'd3;
    localparam logic [2:0] SH_RRX = 3'd4;

    localparam logic [3:0] PC_INDEX = 4'hF;

    localparam int IN_BYTES  = 17;
    localparam int OUT_BYTES = 6;

    // Decoded instruction leaving the first stage.
    typedef struct packed {
        logic        exec;
        logic [3:0]  opc;
        logic        s_bit;
        logic [3:0]  rd;
        logic [3:0]  flags;
        logic [31:0] rn;
        logic [31:0] sh_val;
        logic [2:0]  sh_type;
        logic [7:0]  sh_amt;
    } dec_t;

    // Operands leaving the shifter stage.
    typedef struct packed {
        logic        exec;
        logic [3:0]  opc;
        logic        s_bit;
        logic [3:0]  rd;
        logic [3:0]  flags;
        logic [31:0] rn;
        logic [31:0] op2;
        logic        sc;
    } opnd_t;

    // Result item.
    typedef struct packed {
        logic        restore_status;
        logic        reload_fetch;
        logic [3:0]  flags_out;
        logic [31:0] result;
        logic [3:0]  dest_index;
        logic        write_result;
        logic        executed;
    } res_t;

endpackage

FILE: sv/arm_data_processing_alu_unit.sv
// Three register stages: decode, barrel shifter and ALU each take a stage, and a result
// reaches the output port from the ALU stage register.
// Throughput: one instruction per cycle while the output is not stalled.
// A stalled output holds its stage, and each earlier stage keeps taking data while
// the stage after it has room, so nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties all three stages; payload registers are not cleared.
`include "arm_data_processing_alu_unit_assert.svh"

module arm_data_processing_alu_unit
    import adp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // From bit 0: instruction[31:0], first_operand[31:0], shifted_operand[31:0],
    // shift_amount_register[31:0], flags_in[3:0], four zero bits.
    input  logic [IN_BYTES*8-1:0]    s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // From bit 0: executed, write_result, dest_index[3:0], result[31:0],
    // flags_out[3:0], reload_fetch, restore_status, four zero bits.
    output logic [OUT_BYTES*8-1:0]   m_axis_tdata
);

    logic  dec_valid;
    logic  dec_ready;
    dec_t  dec_data;
    logic  shf_valid;
    logic  shf_ready;
    opnd_t shf_data;
    res_t  res_data;

    adp_decode u_decode (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (s_axis_tvalid),
        .in_ready              (s_axis_tready),
        .instruction           (s_axis_tdata[31:0]),
        .first_operand         (s_axis_tdata[63:32]),
        .shifted_operand       (s_axis_tdata[95:64]),
        .shift_amount_register (s_axis_tdata[127:96]),
        .flags_in              (s_axis_tdata[131:128]),
        .out_valid             (dec_valid),
        .out_ready             (dec_ready),
        .out_data              (dec_data)
    );

    adp_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (shf_valid),
        .out_ready (shf_ready),
        .out_data  (shf_data)
    );

    adp_alu u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (shf_valid),
        .in_ready  (shf_ready),
        .in_data   (shf_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_data)
    );

    assign m_axis_tdata = {{(OUT_BYTES*8-$bits(res_t)){1'b0}}, res_data};

    // An empty output stage lets every earlier stage advance, so input is taken.
    `ADP_ASSERT(a_ready_when_out_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output stage")
    `ADP_ASSERT(a_restore_needs_reload, m_axis_tvalid && res_data.restore_status |-> res_data.reload_fetch, "status restore without PC reload")
    `ADP_ASSERT(a_write_needs_exec, m_axis_tvalid && res_data.write_result |-> res_data.executed, "register write from a failed condition")
    `ADP_ASSERT(a_skipped_result_zero, m_axis_tvalid && !res_data.executed |-> (res_data.result == 32'd0), "non-zero result from a failed condition")
    `ADP_ASSERT_ALWAYS(a_reset_empties, $rose(rst_n) |-> !m_axis_tvalid, "output valid straight after reset")

endmodule

FILE: sv/adp_decode.sv
// First stage: condition test, PC adjustment and shifter operand set-up.
module adp_decode
    import adp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instruction,
    input  logic [31:0] first_operand,
    input  logic [31:0] shifted_operand,
    input  logic [31:0] shift_amount_register,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_t        out_data
);

    localparam logic [1:0] TY_LSL = 2'd0;
    localparam logic [1:0] TY_LSR = 2'd1;
    localparam logic [1:0] TY_ASR = 2'd2;
    localparam logic [1:0] TY_ROR = 2'd3;

    logic  valid_reg;
    dec_t  data_reg;
    dec_t  data_next;
    logic  load;
    logic  pass;
    logic  n_f, z_f, c_f, v_f;
    logic  imm;
    logic  reg_shift;
    logic  [4:0] imm_amt;
    logic  [2:0] ty_code;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        n_f = flags_in[3];
        z_f = flags_in[2];
        c_f = flags_in[1];
        v_f = flags_in[0];
        case (instruction[31:28])
            COND_EQ: pass = z_f;
            COND_NE: pass = !z_f;
            COND_CS: pass = c_f;
            COND_CC: pass = !c_f;
            COND_MI: pass = n_f;
            COND_PL: pass = !n_f;
            COND_VS: pass = v_f;
            COND_VC: pass = !v_f;
            COND_HI: pass = c_f && !z_f;
            COND_LS: pass = !c_f || z_f;
            COND_GE: pass = (n_f == v_f);
            COND_LT: pass = (n_f != v_f);
            COND_GT: pass = !z_f && (n_f == v_f);
            COND_LE: pass = z_f || (n_f != v_f);
            COND_AL: pass = 1'b1;
            default: pass = 1'b0;
        endcase
    end

    always_comb
    begin
        imm       = instruction[25];
        reg_shift = !imm && instruction[4];
        imm_amt   = instruction[11:7];
        case (instruction[6:5])
            TY_LSL:  ty_code = SH_LSL;
            TY_LSR:  ty_code = SH_LSR;
            TY_ASR:  ty_code = SH_ASR;
            default: ty_code = SH_ROR;
        endcase

        data_next.exec  = pass;
        data_next.opc   = instruction[24:21];
        data_next.s_bit = instruction[20];
        data_next.rd    = instruction[15:12];
        data_next.flags = flags_in;
        // Under a register shift the PC reads one word further on.
        data_next.rn    = first_operand +
                          ((reg_shift && instruction[19:16] == PC_INDEX) ? 32'd4 : 32'd0);

        if (imm)
        begin
            data_next.sh_val  = {24'd0, instruction[7:0]};
            data_next.sh_type = SH_ROR;
            data_next.sh_amt  = {3'd0, instruction[11:8], 1'b0};
        end
        else
        begin
            data_next.sh_val = shifted_operand +
                               ((reg_shift && instruction[3:0] == PC_INDEX) ? 32'd4 : 32'd0);
            if (reg_shift)
            begin
                data_next.sh_type = ty_code;
                data_next.sh_amt  = shift_amount_register[7:0];
            end
            else if (imm_amt != 5'd0)
            begin
                data_next.sh_type = ty_code;
                data_next.sh_amt  = {3'd0, imm_amt};
            end
            else
            begin
                // A zero immediate amount means no shift, a shift by 32, or RRX.
                case (instruction[6:5])
                    TY_LSL:
                    begin
                        data_next.sh_type = SH_LSL;
                        data_next.sh_amt  = 8'd0;
                    end
                    TY_ROR:
                    begin
                        data_next.sh_type = SH_RRX;
                        data_next.sh_amt  = 8'd1;
                    end
                    default:
                    begin
                        data_next.sh_type = ty_code;
                        data_next.sh_amt  = 8'd32;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: sv/adp_shift.sv
// Second stage: barrel shifter producing the second operand and shifter carry.
module adp_shift
    import adp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  dec_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output opnd_t out_data
);

    logic         valid_reg;
    opnd_t        data_reg;
    opnd_t        data_next;
    logic         load;
    logic [4:0]   n5;
    logic         big;
    logic         eq32;
    logic         c_in;
    logic [31:0]  val;
    logic [32:0]  t;
    logic [63:0]  rot;
    logic [31:0]  op2;
    logic         sc;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        val  = in_data.sh_val;
        n5   = in_data.sh_amt[4:0];
        big  = |in_data.sh_amt[7:5];
        eq32 = (in_data.sh_amt == 8'd32);
        c_in = in_data.flags[1];
        t    = 33'd0;
        rot  = {val, val} >> n5;
        case (in_data.sh_type)
            SH_LSL:
            begin
                t = {1'b0, val} << n5;
                if (big)
                begin
                    op2 = 32'd0;
                    sc  = eq32 ? val[0] : 1'b0;
                end
                else
                begin
                    op2 = t[31:0];
                    sc  = t[32];
                end
            end
            SH_LSR:
            begin
                t = {val, 1'b0} >> n5;
                if (big)
                begin
                    op2 = 32'd0;
                    sc  = eq32 ? val[31] : 1'b0;
                end
                else
                begin
                    op2 = t[32:1];
                    sc  = t[0];
                end
            end
            SH_ASR:
            begin
                t = 33'($signed({val, 1'b0}) >>> n5);
                if (big)
                begin
                    op2 = {32{val[31]}};
                    sc  = val[31];
                end
                else
                begin
                    op2 = t[32:1];
                    sc  = t[0];
                end
            end
            SH_ROR:
            begin
                // Amounts that are a multiple of 32 leave the value in place.
                op2 = rot[31:0];
                sc  = rot[31];
            end
            SH_RRX:
            begin
                op2 = {c_in, val[31:1]};
                sc  = val[0];
            end
            default:
            begin
                op2 = val;
                sc  = c_in;
            end
        endcase
        if (in_data.sh_amt == 8'd0)
        begin
            op2 = val;
            sc  = c_in;
        end

        data_next.exec  = in_data.exec;
        data_next.opc   = in_data.opc;
        data_next.s_bit = in_data.s_bit;
        data_next.rd    = in_data.rd;
        data_next.flags = in_data.flags;
        data_next.rn    = in_data.rn;
        data_next.op2   = op2;
        data_next.sc    = sc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: sv/adp_alu.sv
// Third stage: ALU operation, flag update and the output register.
module adp_alu
    import adp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  opnd_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_data
);

    logic         valid_reg;
    res_t         data_reg;
    res_t         data_next;
    logic         load;
    logic [31:0]  a;
    logic [31:0]  b;
    logic         ci;
    logic         arith;
    logic [31:0]  logic_res;
    logic [32:0]  sum;
    logic [31:0]  res;
    logic         carry;
    logic         ovf;
    logic         writes;
    logic         restore;
    logic         c_in;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        c_in      = in_data.flags[1];
        a         = in_data.rn;
        b         = ~in_data.op2;
        ci        = 1'b1;
        arith     = 1'b1;
        logic_res = 32'd0;
        case (in_data.opc)
            OP_AND, OP_TST:
            begin
                arith     = 1'b0;
                logic_res = in_data.rn & in_data.op2;
            end
            OP_EOR, OP_TEQ:
            begin
                arith     = 1'b0;
                logic_res = in_data.rn ^ in_data.op2;
            end
            OP_SUB, OP_CMP:
            begin
                a  = in_data.rn;
                b  = ~in_data.op2;
                ci = 1'b1;
            end
            OP_RSB:
            begin
                a  = in_data.op2;
                b  = ~in_data.rn;
                ci = 1'b1;
            end
            OP_ADD, OP_CMN:
            begin
                a  = in_data.rn;
                b  = in_data.op2;
                ci = 1'b0;
            end
            OP_ADC:
            begin
                a  = in_data.rn;
                b  = in_data.op2;
                ci = c_in;
            end
            OP_SBC:
            begin
                a  = in_data.rn;
                b  = ~in_data.op2;
                ci = c_in;
            end
            OP_RSC:
            begin
                a  = in_data.op2;
                b  = ~in_data.rn;
                ci = c_in;
            end
            OP_ORR:
            begin
                arith     = 1'b0;
                logic_res = in_data.rn | in_data.op2;
            end
            OP_MOV:
            begin
                arith     = 1'b0;
                logic_res = in_data.op2;
            end
            OP_BIC:
            begin
                arith     = 1'b0;
                logic_res = in_data.rn & ~in_data.op2;
            end
            default:
            begin
                arith     = 1'b0;
                logic_res = ~in_data.op2;
            end
        endcase

        sum = {1'b0, a} + {1'b0, b} + {32'd0, ci};
        if (arith)
        begin
            res   = sum[31:0];
            carry = sum[32];
            ovf   = (a[31] ^ res[31]) & (b[31] ^ res[31]);
        end
        else
        begin
            res   = logic_res;
            carry = in_data.sc;
            ovf   = in_data.flags[0];
        end

        // The four compare operations are the only ones that do not write.
        writes  = (in_data.opc[3:2] != 2'b10);
        restore = in_data.exec && in_data.s_bit && writes && (in_data.rd == PC_INDEX);

        data_next.executed       = in_data.exec;
        data_next.write_result   = in_data.exec && writes;
        data_next.dest_index     = in_data.rd;
        data_next.result         = in_data.exec ? res : 32'd0;
        data_next.reload_fetch   = in_data.exec && writes && (in_data.rd == PC_INDEX);
        data_next.restore_status = restore;
        if (in_data.exec && in_data.s_bit && !restore)
        begin
            data_next.flags_out = {res[31], (res == 32'd0), carry, ovf};
        end
        else
        begin
            data_next.flags_out = in_data.flags;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule
